// ===== rtl/pcpc_pkg.sv =====
package pcpc_pkg;

  // Command codes of an input transaction
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_ENCRYPT = 2'd1;
  localparam logic [1:0] CMD_DECRYPT = 2'd2;

  // Fixed field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned INDEX_W = 7;
  localparam int unsigned CHAR_W  = 8;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift;   // take the neighbor's entry (ring rotates one place)
    logic write;   // take the load data
  } cell_ctrl_t;

endpackage

// ===== rtl/printable_char_progressive_cipher.sv =====
// Progressive substitution cipher over ALPHABET_SIZE characters starting at
// ALPHABET_BASE (32..126 by default). The base permutation lives in a ring of
// ALPHABET_SIZE cells that rotates one place per cycle; the cell at the head
// is the only one compared or read. Per transaction: a load, an unused
// command or a character outside the alphabet goes straight to the done
// state; an encrypt makes one full turn of the ring and keeps the match with
// the lowest row place; a decrypt turns the ring until the wanted entry
// reaches the head. Each result then passes through the done state into
// the output register. A new transaction is taken once the previous one
// has moved into the output register, so the result may wait there while
// the next one runs.
// Reset loads the identity permutation and message position zero at once.
module printable_char_progressive_cipher #(
  parameter int unsigned ALPHABET_SIZE = 95,
  parameter int unsigned ALPHABET_BASE = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [pcpc_pkg::CMD_W-1:0]      in_command,
  input  logic [pcpc_pkg::INDEX_W-1:0]    in_table_index,
  input  logic [pcpc_pkg::CHAR_W-1:0]     in_char_in,
  input  logic                            in_last_char,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pcpc_pkg::CHAR_W-1:0]     out_char_out,
  output logic                            out_error_flag
);

  localparam int unsigned AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam logic [AW-1:0] LAST = AW'(ALPHABET_SIZE - 1);
  localparam logic [AW:0]   SIZE_X = (AW+1)'(ALPHABET_SIZE);
  localparam int unsigned   CW = pcpc_pkg::CHAR_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_ALIGN  = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;     // message position
  logic [AW-1:0] rot_r, rot_nxt;     // logical entry held at the head cell
  logic [AW-1:0] key_r, key_nxt;     // encrypt: offset sought; decrypt: target entry
  logic [AW-1:0] j_r, j_nxt;         // row place of the head entry
  logic [AW-1:0] cnt_r, cnt_nxt;     // compares left in the turn
  logic [AW-1:0] best_r, best_nxt;
  logic          found_r, found_nxt;
  logic [CW-1:0] res_char_r, res_char_nxt;
  logic          res_err_r, res_err_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_char_r, out_char_nxt;
  logic          out_err_r, out_err_nxt;

  logic          shift;
  logic          load_we;
  logic [AW-1:0] wr_phys;
  logic [AW-1:0] cell_data [ALPHABET_SIZE];
  logic [AW-1:0] head;

  // Input decode
  logic [CW:0]   ch_diff;
  logic          ch_ok;
  logic [AW-1:0] off;
  logic          idx_ok;
  logic [AW-1:0] idx_a;
  logic [AW:0]   row_diff;
  logic [AW:0]   dec_sum;
  logic [AW:0]   phys_diff;
  logic          hit;
  logic          accept;

  assign head    = cell_data[0];
  assign accept  = in_valid && in_ready;
  assign ch_diff = {1'b0, in_char_in} - (CW+1)'(ALPHABET_BASE);
  assign ch_ok   = (in_char_in >= CW'(ALPHABET_BASE)) &&
                   (ch_diff < (CW+1)'(ALPHABET_SIZE));
  assign off     = ch_diff[AW-1:0];
  assign idx_ok  = {1'b0, in_table_index} < (pcpc_pkg::INDEX_W+1)'(ALPHABET_SIZE);
  assign idx_a   = in_table_index[AW-1:0];

  // Modular differences and sums, one compare-subtract each
  always_comb begin
    row_diff = (rot_r >= pos_r) ? ({1'b0, rot_r} - {1'b0, pos_r})
                                : ({1'b0, rot_r} + SIZE_X - {1'b0, pos_r});
    dec_sum  = {1'b0, pos_r} + {1'b0, off};
    if (dec_sum >= SIZE_X) begin
      dec_sum = dec_sum - SIZE_X;
    end
    phys_diff = (idx_a >= rot_r) ? ({1'b0, idx_a} - {1'b0, rot_r})
                                 : ({1'b0, idx_a} + SIZE_X - {1'b0, rot_r});
  end
  assign wr_phys = phys_diff[AW-1:0];

  assign hit   = (state_r == S_SEARCH) && (head == key_r) && (!found_r || (j_r < best_r));
  assign shift = (state_r == S_SEARCH) || ((state_r == S_ALIGN) && (rot_r != key_r));
  assign load_we = accept && (in_command == pcpc_pkg::CMD_LOAD) && idx_ok && ch_ok;
  assign in_ready = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    res_char_nxt  = res_char_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_err_nxt   = out_err_r;
    rot_nxt       = shift ? ((rot_r == LAST) ? '0 : rot_r + 1'b1) : rot_r;

    // Drop the delivered result
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_char_nxt = '0;
          res_err_nxt  = 1'b0;
          state_nxt    = S_DONE;
          unique case (in_command)
            pcpc_pkg::CMD_LOAD: begin
              res_err_nxt = !(idx_ok && ch_ok);
            end
            pcpc_pkg::CMD_ENCRYPT: begin
              if (ch_ok) begin
                key_nxt   = off;
                j_nxt     = row_diff[AW-1:0];
                cnt_nxt   = LAST;
                found_nxt = 1'b0;
                best_nxt  = '0;
                state_nxt = S_SEARCH;
              end else begin
                res_err_nxt = 1'b1;
              end
            end
            pcpc_pkg::CMD_DECRYPT: begin
              if (ch_ok) begin
                key_nxt   = dec_sum[AW-1:0];
                state_nxt = S_ALIGN;
              end else begin
                res_err_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
          // Advance the position on every cipher transaction, back to zero after the last character
          if ((in_command == pcpc_pkg::CMD_ENCRYPT) ||
              (in_command == pcpc_pkg::CMD_DECRYPT)) begin
            pos_nxt = (in_last_char || (pos_r == LAST)) ? '0 : pos_r + 1'b1;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          found_nxt = 1'b1;
          best_nxt  = j_r;
        end
        j_nxt = (j_r == LAST) ? '0 : j_r + 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
          if (hit || found_r) begin
            res_char_nxt = CW'(hit ? j_r : best_r) + CW'(ALPHABET_BASE);
            res_err_nxt  = 1'b0;
          end else begin
            res_char_nxt = '0;
            res_err_nxt  = 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_ALIGN: begin
        if (rot_r == key_r) begin
          res_char_nxt = CW'(head) + CW'(ALPHABET_BASE);
          res_err_nxt  = 1'b0;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        // Hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = res_char_r;
          out_err_nxt   = res_err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      rot_r       <= rot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    j_r        <= j_nxt;
    cnt_r      <= cnt_nxt;
    best_r     <= best_nxt;
    found_r    <= found_nxt;
    res_char_r <= res_char_nxt;
    res_err_r  <= res_err_nxt;
    out_char_r <= out_char_nxt;
    out_err_r  <= out_err_nxt;
  end

  // Ring of cells, rotating left: each cell takes its right neighbor
  for (genvar p = 0; p < ALPHABET_SIZE; p++) begin : g_cell
    localparam int unsigned NX = (p + 1) % ALPHABET_SIZE;
    pcpc_pkg::cell_ctrl_t ctrl;
    assign ctrl.shift = shift;
    assign ctrl.write = load_we && (wr_phys == AW'(p));
    pcpc_cell #(
      .W    (AW),
      .INIT (p)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .nbr_data (cell_data[NX]),
      .wr_data  (off),
      .data     (cell_data[p])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_char_out   = out_char_r;
  assign out_error_flag = out_err_r;

  // Checks
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST)
    else $error("message position out of range");

  a_no_shift_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !shift)
    else $error("ring rotated outside a search");

  a_align_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALIGN && rot_r == key_r) |=> (state_r == S_DONE))
    else $error("aligned decrypt did not finish");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_char_r == '0))
    else $error("error result carries a character");

endmodule

// ===== rtl/pcpc_cell.sv =====
module pcpc_cell #(
  parameter int unsigned W    = 7,
  parameter int unsigned INIT = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcpc_pkg::cell_ctrl_t  ctrl,
  input  logic [W-1:0]          nbr_data,
  input  logic [W-1:0]          wr_data,
  output logic [W-1:0]          data
);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;

  // Load beats rotation; the sequencer never asks for both
  always_comb begin
    data_nxt = data_r;
    if (ctrl.write) begin
      data_nxt = wr_data;
    end else if (ctrl.shift) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= W'(INIT);
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data = data_r;

endmodule
